// ===== design/moebius_surface_normal_macros.svh =====
// Assertion shorthands used by moebius_surface_normal.sv to check its own logic.
`ifndef MOEBIUS_SURFACE_NORMAL_MACROS_SVH
`define MOEBIUS_SURFACE_NORMAL_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define MSN_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define MSN_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/msn_pkg.sv =====
`timescale 1ns / 1ps
package msn_pkg;

	localparam int unsigned COORD_W   = 32;
	localparam int unsigned RADIUS_W  = 31;
	localparam int unsigned DATA_W    = 3 * COORD_W;
	localparam int unsigned REG_IDX_W = 2;
	localparam int unsigned MAG_W     = 30;
	localparam int unsigned SUM_W     = 2 * MAG_W + 2;
	localparam int unsigned LEN_W     = 31;
	localparam int unsigned QUO_W     = 31;

	localparam logic signed [66:0] SAT_HI = 67'sd9223372036854775807;
	localparam logic signed [63:0] LIM64  = 64'sd9223372036854775807;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ORIGIN_X    = 2'd0,
		REG_ORIGIN_Y    = 2'd1,
		REG_ORIGIN_Z    = 2'd2,
		REG_RING_RADIUS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} msn_flags_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] a;
		msn_flags_t            flags;
	} msn_side_t;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v > 33'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -33'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [66:0] ext67(input logic signed [63:0] x);
		return 67'(x);
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [66:0] v);
		if (v > SAT_HI)
			return LIM64;
		else if (v < -SAT_HI)
			return -LIM64;
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] sc2(input logic signed [63:0] x);
		return sat64(ext67(x) <<< 1);
	endfunction

	function automatic logic signed [63:0] sc3(input logic signed [63:0] x);
		return sat64(ext67(x) + (ext67(x) <<< 1));
	endfunction

	function automatic logic signed [63:0] sc4(input logic signed [63:0] x);
		return sat64(ext67(x) <<< 2);
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return sat64(ext67(a) + ext67(b));
	endfunction

endpackage

// ===== design/moebius_surface_normal.sv =====
`timescale 1ns / 1ps
// Unit surface normal of a Moebius strip at a ray hit point.
// Input stream s_*: one hit point per item, x, y and z in Q16.16.
// Output stream m_*: one normal per item, x, y and z in Q2.30, and a flag in
// m_tuser that marks a zero gradient (the normal is then all zero).
// The strip centre and ring radius are set through cfg_we, cfg_addr and
// cfg_wdata while no item is in flight; register 0 to 2 are the origin
// axes, register 3 the ring radius.
// Throughput is one item per clock while the output is not stalled. There
// are 79 register stages from the input to m_tvalid. The stages are 15 for
// offset, products, scaling, saturating sums, magnitudes, normalising and the
// sum of squares, 32 of square root (one root bit each) and 31 of division
// (one quotient bit each, three lanes side by side), then the sign and output register.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready falls; nothing is dropped or repeated.
// Reset clears every valid bit, sets the origin to zero and the radius to 1.0.
`include "moebius_surface_normal_macros.svh"
module moebius_surface_normal (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [msn_pkg::REG_IDX_W-1:0]     cfg_addr,
	input  logic [msn_pkg::COORD_W-1:0]       cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// point_x [31:0], point_y [63:32], point_z [95:64]
	input  logic [msn_pkg::DATA_W-1:0]        s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// normal_x [31:0], normal_y [63:32], normal_z [95:64]
	output logic [msn_pkg::DATA_W-1:0]        m_tdata,
	// degenerate [0]
	output logic                              m_tuser
);
	import msn_pkg::*;

	logic en;

	logic signed [COORD_W-1:0]  origin_x_q, origin_y_q, origin_z_q;
	logic        [RADIUS_W-1:0] ring_radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			origin_z_q    <= '0;
			ring_radius_q <= RADIUS_W'(65536);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_ORIGIN_X:    origin_x_q    <= cfg_wdata;
				REG_ORIGIN_Y:    origin_y_q    <= cfg_wdata;
				REG_ORIGIN_Z:    origin_z_q    <= cfg_wdata;
				REG_RING_RADIUS: ring_radius_q <= cfg_wdata[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless a result waits on a stalled receiver.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [COORD_W-1:0] px, py, pz, r_sgn;
	assign px    = s_tdata[COORD_W-1:0];
	assign py    = s_tdata[2*COORD_W-1:COORD_W];
	assign pz    = s_tdata[3*COORD_W-1:2*COORD_W];
	assign r_sgn = $signed({1'b0, ring_radius_q});

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s79;

	logic             sq_vld;
	logic [LEN_W-1:0] sq_len;
	msn_side_t        sq_side;

	logic                  dv_vld;
	logic [2:0][QUO_W-1:0] dv_q;
	msn_flags_t            dv_flags;

	// Stage 1: offset from the strip centre.
	logic signed [COORD_W-1:0] cx_s1, cy_s1, cz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= sat32($signed({px[COORD_W-1], px}) - $signed({origin_x_q[COORD_W-1], origin_x_q}));
			cy_s1 <= sat32($signed({py[COORD_W-1], py}) - $signed({origin_y_q[COORD_W-1], origin_y_q}));
			cz_s1 <= sat32($signed({pz[COORD_W-1], pz}) - $signed({origin_z_q[COORD_W-1], origin_z_q}));
		end
	end

	// Stage 2: the nine exact products.
	logic signed [63:0] p_cxcy_s2, p_rcz_s2, p_cxcz_s2, p_rr_s2, p_cxcx_s2;
	logic signed [63:0] p_cycy_s2, p_cycz_s2, p_czcz_s2, p_rcx_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			p_cxcy_s2 <= cx_s1 * cy_s1;
			p_rcz_s2  <= r_sgn * cz_s1;
			p_cxcz_s2 <= cx_s1 * cz_s1;
			p_rr_s2   <= r_sgn * r_sgn;
			p_cxcx_s2 <= cx_s1 * cx_s1;
			p_cycy_s2 <= cy_s1 * cy_s1;
			p_cycz_s2 <= cy_s1 * cz_s1;
			p_czcz_s2 <= cz_s1 * cz_s1;
			p_rcx_s2  <= r_sgn * cx_s1;
		end
	end

	// Stage 3: scaled and signed terms, each scaled term saturated on its own.
	logic signed [63:0] gx_a_s3, gx_b_s3, gx_c_s3;
	logic signed [63:0] gy_a_s3, gy_b_s3, gy_c_s3, gy_d_s3, gy_e_s3;
	logic signed [63:0] gz_a_s3, gz_b_s3, gz_c_s3, gz_d_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			gx_a_s3 <= sc2(p_cxcy_s2);
			gx_b_s3 <= -sc2(p_rcz_s2);
			gx_c_s3 <= -sc4(p_cxcz_s2);
			gy_a_s3 <= -p_rr_s2;
			gy_b_s3 <= p_cxcx_s2;
			gy_c_s3 <= sc3(p_cycy_s2);
			gy_d_s3 <= -sc4(p_cycz_s2);
			gy_e_s3 <= p_czcz_s2;
			gz_a_s3 <= -sc2(p_rcx_s2);
			gz_b_s3 <= -sc2(p_cxcx_s2);
			gz_c_s3 <= -sc2(p_cycy_s2);
			gz_d_s3 <= sc2(p_cycz_s2);
		end
	end

	// Stages 4 to 7: saturating sums in their fixed order, at most one add per sum a stage.
	logic signed [63:0] gx_s4, gx_c_s4, gy_s4, gy_c_s4, gy_d_s4, gy_e_s4;
	logic signed [63:0] gz_s4, gz_c_s4, gz_d_s4;
	logic signed [63:0] gx_s5, gy_s5, gy_d_s5, gy_e_s5, gz_s5, gz_d_s5;
	logic signed [63:0] gx_s6, gy_s6, gy_e_s6, gz_s6;
	logic signed [63:0] gx_s7, gy_s7, gz_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			gx_s4   <= sadd(gx_a_s3, gx_b_s3);
			gx_c_s4 <= gx_c_s3;
			gy_s4   <= sadd(gy_a_s3, gy_b_s3);
			gy_c_s4 <= gy_c_s3;
			gy_d_s4 <= gy_d_s3;
			gy_e_s4 <= gy_e_s3;
			gz_s4   <= sadd(gz_a_s3, gz_b_s3);
			gz_c_s4 <= gz_c_s3;
			gz_d_s4 <= gz_d_s3;

			gx_s5   <= sadd(gx_s4, gx_c_s4);
			gy_s5   <= sadd(gy_s4, gy_c_s4);
			gy_d_s5 <= gy_d_s4;
			gy_e_s5 <= gy_e_s4;
			gz_s5   <= sadd(gz_s4, gz_c_s4);
			gz_d_s5 <= gz_d_s4;

			gx_s6   <= gx_s5;
			gy_s6   <= sadd(gy_s5, gy_d_s5);
			gy_e_s6 <= gy_e_s5;
			gz_s6   <= sadd(gz_s5, gz_d_s5);

			gx_s7   <= gx_s6;
			gy_s7   <= sadd(gy_s6, gy_e_s6);
			gz_s7   <= gz_s6;
		end
	end

	logic [2:0][63:0] g7;
	assign g7 = {gz_s7, gy_s7, gx_s7};

	// Stages 8 to 12: magnitudes, their maximum and its leading one.
	logic [2:0][62:0] a_s8, a_s9, a_s10, a_s11, a_s12;
	logic [2:0]       neg_s8, neg_s9, neg_s10, neg_s11, neg_s12;
	logic [62:0]      m01_s9, m_s10;
	logic [7:0]       nz_s11;
	logic [7:0][2:0]  pos_s11;
	logic [5:0]       msb_s12;
	logic             degen_s12;
	logic [7:0][2:0]  pos_c;
	logic [7:0]       nz_c;
	logic [5:0]       msb_c;

	always_comb begin
		logic [63:0] mw;
		mw = {1'b0, m_s10};
		for (int gi = 0; gi < 8; gi++) begin
			pos_c[gi] = '0;
			nz_c[gi]  = |mw[8*gi +: 8];
			for (int b = 0; b < 8; b++) begin
				if (mw[8*gi+b])
					pos_c[gi] = 3'(b);
			end
		end
	end

	always_comb begin
		msb_c = '0;
		for (int gi = 0; gi < 8; gi++) begin
			if (nz_s11[gi])
				msb_c = {3'(gi), pos_s11[gi]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s8[i]   <= g7[i][63] ? 63'(64'd0 - g7[i]) : g7[i][62:0];
				neg_s8[i] <= g7[i][63];
			end

			a_s9   <= a_s8;
			neg_s9 <= neg_s8;
			m01_s9 <= (a_s8[0] > a_s8[1]) ? a_s8[0] : a_s8[1];

			a_s10   <= a_s9;
			neg_s10 <= neg_s9;
			m_s10   <= (m01_s9 > a_s9[2]) ? m01_s9 : a_s9[2];

			a_s11   <= a_s10;
			neg_s11 <= neg_s10;
			nz_s11  <= nz_c;
			pos_s11 <= pos_c;

			a_s12     <= a_s11;
			neg_s12   <= neg_s11;
			msb_s12   <= msb_c;
			degen_s12 <= ~|nz_s11;
		end
	end

	// Stage 13: shift all three so that the largest lies in [2^29, 2^30).
	logic [2:0][MAG_W-1:0] a_n;
	always_comb begin
		logic [63:0] shv;
		for (int i = 0; i < 3; i++) begin
			if (msb_s12 > 6'd29)
				shv = {1'b0, a_s12[i]} >> (msb_s12 - 6'd29);
			else
				shv = {1'b0, a_s12[i]} << (6'd29 - msb_s12);
			a_n[i] = shv[MAG_W-1:0];
		end
	end

	msn_side_t side_s13, side_s14, side_s15;
	logic [2:0][2*MAG_W-1:0] sq_s14;
	logic [SUM_W-1:0] sum_s15;
	always_ff @(posedge clk) begin
		if (en) begin
			side_s13.a           <= a_n;
			side_s13.flags.neg   <= neg_s12;
			side_s13.flags.degen <= degen_s12;

			side_s14 <= side_s13;
			for (int i = 0; i < 3; i++)
				sq_s14[i] <= side_s13.a[i] * side_s13.a[i];

			side_s15 <= side_s14;
			sum_s15  <= SUM_W'(sq_s14[0]) + SUM_W'(sq_s14[1]) + SUM_W'(sq_s14[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
			{vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15} <= '0;
			vld_s79 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s79 <= dv_vld;
		end
	end

	msn_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s15),
		.in_sum   (sum_s15),
		.in_side  (side_s15),
		.out_vld  (sq_vld),
		.out_len  (sq_len),
		.out_side (sq_side)
	);

	msn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (sq_vld),
		.in_len    (sq_len),
		.in_a      (sq_side.a),
		.in_flags  (sq_side.flags),
		.out_vld   (dv_vld),
		.out_q     (dv_q),
		.out_flags (dv_flags)
	);

	// Output register: sign restored, zero vector for a zero gradient.
	logic [2:0][COORD_W-1:0] norm_s79;
	logic                    degen_s79;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				if (dv_flags.degen)
					norm_s79[l] <= '0;
				else if (dv_flags.neg[l])
					norm_s79[l] <= COORD_W'(0) - COORD_W'(dv_q[l]);
				else
					norm_s79[l] <= COORD_W'(dv_q[l]);
			end
			degen_s79 <= dv_flags.degen;
		end
	end

	assign m_tvalid = vld_s79;
	assign m_tdata  = norm_s79;
	assign m_tuser  = degen_s79;

	`MSN_ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser, m_tdata == '0, "degenerate item carries a non-zero normal")
	`MSN_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken while the output is stalled")
	`MSN_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, vld_s1, "accepted item missing from the first stage")
	`MSN_ASSERT_IMP(a_x_range, m_tvalid, ($signed(m_tdata[31:0]) <= 32'sd1073741824) && ($signed(m_tdata[31:0]) >= -32'sd1073741824), "normal x beyond unit range")

endmodule

// ===== design/msn_isqrt.sv =====
`timescale 1ns / 1ps
module msn_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [msn_pkg::SUM_W-1:0]  in_sum,
	input  msn_pkg::msn_side_t         in_side,
	output logic                       out_vld,
	output logic [msn_pkg::LEN_W-1:0]  out_len,
	output msn_pkg::msn_side_t         out_side
);
	import msn_pkg::*;

	localparam int unsigned STEPS = LEN_W + 1;
	localparam int unsigned W     = 2 * STEPS - 1;

	logic [STEPS-1:0] vld_s;
	logic [W-1:0]     rem_s  [STEPS];
	logic [W-1:0]     root_s [STEPS];
	msn_side_t        side_s [STEPS];

	// One root bit per stage, from the top pair of bits of the radicand down.
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [W-1:0] BIT = W'(1) << (2 * (STEPS - 1 - k));
		logic         vld_i;
		logic [W-1:0] rem_i;
		logic [W-1:0] root_i;
		logic [W-1:0] trial;
		msn_side_t    side_i;

		if (k == 0) begin : g_first
			assign vld_i  = in_vld;
			assign rem_i  = W'(in_sum);
			assign root_i = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = root_i + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= trial) begin
					rem_s[k]  <= rem_i - trial;
					root_s[k] <= (root_i >> 1) + BIT;
				end else begin
					rem_s[k]  <= rem_i;
					root_s[k] <= root_i >> 1;
				end
				side_s[k] <= side_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end
	end

	assign out_vld  = vld_s[STEPS-1];
	assign out_len  = root_s[STEPS-1][LEN_W-1:0];
	assign out_side = side_s[STEPS-1];

endmodule

// ===== design/msn_div.sv =====
`timescale 1ns / 1ps
module msn_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic [msn_pkg::LEN_W-1:0]         in_len,
	input  logic [2:0][msn_pkg::MAG_W-1:0]    in_a,
	input  msn_pkg::msn_flags_t               in_flags,
	output logic                              out_vld,
	output logic [2:0][msn_pkg::QUO_W-1:0]    out_q,
	output msn_pkg::msn_flags_t               out_flags
);
	import msn_pkg::*;

	localparam int unsigned STEPS = QUO_W;
	localparam int unsigned RW    = LEN_W + 1;

	logic [STEPS-1:0]            vld_s;
	logic [LEN_W-1:0]            len_s   [STEPS];
	logic [2:0][LEN_W-1:0]       rem_s   [STEPS];
	logic [2:0][QUO_W-1:0]       q_s     [STEPS];
	msn_flags_t                  flags_s [STEPS];

	// Restoring division of a * 2^30 by the length, one quotient bit per stage.
	// The quotient never exceeds 2^30, so the dividend bits above that are
	// taken in at once: the first partial remainder is a itself.
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic                  vld_i;
		logic [LEN_W-1:0]      len_i;
		logic [2:0][RW-1:0]    rr_i;
		logic [2:0][QUO_W-1:0] q_i;
		msn_flags_t            flags_i;

		if (k == 0) begin : g_first
			assign vld_i   = in_vld;
			assign len_i   = in_len;
			assign q_i     = '0;
			assign flags_i = in_flags;
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rr_i[l] = RW'(in_a[l]);
			end
		end else begin : g_next
			assign vld_i   = vld_s[k-1];
			assign len_i   = len_s[k-1];
			assign q_i     = q_s[k-1];
			assign flags_i = flags_s[k-1];
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rr_i[l] = {rem_s[k-1][l], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[k]   <= len_i;
				flags_s[k] <= flags_i;
				for (int l = 0; l < 3; l++) begin
					if (rr_i[l] >= {1'b0, len_i}) begin
						rem_s[k][l] <= LEN_W'(rr_i[l] - {1'b0, len_i});
						q_s[k][l]   <= {q_i[l][QUO_W-2:0], 1'b1};
					end else begin
						rem_s[k][l] <= rr_i[l][LEN_W-1:0];
						q_s[k][l]   <= {q_i[l][QUO_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end
	end

	assign out_vld   = vld_s[STEPS-1];
	assign out_q     = q_s[STEPS-1];
	assign out_flags = flags_s[STEPS-1];

endmodule
